// ----- rtl/kst_pkg.sv -----
// Shared types, constants and key decode for the key state tracker.
// Used by kst_ctrl, kst_datapath and key_state_tracker; no dependencies.
`timescale 1ns / 1ps

package kst_pkg;

  // Capacity of the held-key list.
  localparam int MAX_KEYS = 16;
  // Count holds 0..MAX_KEYS; index addresses 0..MAX_KEYS-1.
  localparam int CNT_W = $clog2(MAX_KEYS + 1);
  localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

  // Field widths of the stream payloads.
  localparam int KEY_W  = 8;
  localparam int TS_W   = 32;
  localparam int MASK_W = 3;
  localparam int HELD_W = 5;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 56;

  // Key codes of interest.
  localparam logic [KEY_W-1:0] KC_BACKSPACE = 8'd14;
  localparam logic [KEY_W-1:0] KC_LCTRL     = 8'd29;
  localparam logic [KEY_W-1:0] KC_RCTRL     = 8'd97;
  localparam logic [KEY_W-1:0] KC_LALT      = 8'd56;
  localparam logic [KEY_W-1:0] KC_RALT      = 8'd100;
  localparam logic [KEY_W-1:0] KC_LMETA     = 8'd125;
  localparam logic [KEY_W-1:0] KC_RMETA     = 8'd126;

  // Modifier mask bits.
  localparam logic [MASK_W-1:0] MOD_NONE  = 3'b000;
  localparam logic [MASK_W-1:0] MOD_CTRL  = 3'b001;
  localparam logic [MASK_W-1:0] MOD_ALT   = 3'b010;
  localparam logic [MASK_W-1:0] MOD_SUPER = 3'b100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input item, start the scan
    logic check;    // terminate test and modifier update
    logic rd_k;     // read the entry at the scan position
    logic rd_last;  // drop the last entry and read it
    logic swap_wr;  // write the swapped-in entry at the scan position
    logic step_k;   // advance the scan position
    logic append;   // store a pressed key and commit the count
    logic emit;     // load the result into the output register
  } kst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_term;    // backspace with exactly ctrl+alt held
    logic scan_done;  // scan position reached the end of the list
    logic hit;        // entry just read matches the key
    logic out_free;   // output register can take a result
  } kst_sts_t;

  function automatic logic [MASK_W-1:0] modifier_of(input logic [KEY_W-1:0] key);
    logic [MASK_W-1:0] mod;
    case (key)
      KC_LCTRL, KC_RCTRL: mod = MOD_CTRL;
      KC_LALT, KC_RALT:   mod = MOD_ALT;
      KC_LMETA, KC_RMETA: mod = MOD_SUPER;
      default:            mod = MOD_NONE;
    endcase
    return mod;
  endfunction

endpackage

// ----- rtl/kst_ctrl.sv -----
// Sequencing state machine of the key state tracker.
// Depends on kst_pkg for the command and status structs.
`timescale 1ns / 1ps

module kst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  kst_pkg::kst_sts_t sts,
  output kst_pkg::kst_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_READ   = 7'b0000100,
    ST_CMP    = 7'b0001000,
    ST_SWAP   = 7'b0010000,
    ST_APPEND = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.is_term ? ST_DONE : ST_READ;
      end
      ST_READ: begin
        if (sts.scan_done) begin
          state_nxt = ST_APPEND;
        end else begin
          cmd.rd_k  = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          cmd.rd_last = 1'b1;
          state_nxt   = ST_SWAP;
        end else begin
          cmd.step_k = 1'b1;
          state_nxt  = ST_READ;
        end
      end
      ST_SWAP: begin
        cmd.swap_wr = 1'b1;
        cmd.step_k  = 1'b1;
        state_nxt   = ST_READ;
      end
      ST_APPEND: begin
        cmd.append = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("kst_ctrl: ready again right after an accepted item");
`endif

endmodule

// ----- rtl/kst_datapath.sv -----
// Datapath of the key state tracker: input capture, held-key memory,
// scan counters, modifier mask and the output register. Depends on kst_pkg.
`timescale 1ns / 1ps

module kst_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [kst_pkg::IN_W-1:0]  in_tdata,
  input  logic                      out_tready,
  output logic                      out_tvalid,
  output logic [kst_pkg::OUT_W-1:0] out_tdata,
  input  kst_pkg::kst_cmd_t         cmd,
  output kst_pkg::kst_sts_t         sts
);

  localparam int CNT_W = kst_pkg::CNT_W;
  localparam int IDX_W = kst_pkg::IDX_W;

  // Captured item.
  logic [kst_pkg::KEY_W-1:0] key_r;
  logic                      press_r;
  logic                      focus_r;
  logic [kst_pkg::TS_W-1:0]  ts_r;
  logic                      term_r;
  logic                      ovf_r;

  // Persistent state and scan counters.
  logic [kst_pkg::MASK_W-1:0] mask_r;
  logic [CNT_W-1:0]           count_r;
  logic [CNT_W-1:0]           k_r;
  logic [CNT_W-1:0]           end_r;

  logic [kst_pkg::KEY_W-1:0] mem [kst_pkg::MAX_KEYS];
  logic [kst_pkg::KEY_W-1:0] rdata_r;

  logic                       out_valid_r;
  logic [kst_pkg::OUT_W-1:0]  out_data_r;
  logic [kst_pkg::OUT_W-1:0]  out_nxt;

  logic [CNT_W-1:0]           end_dec;
  logic [IDX_W-1:0]           rd_idx;
  logic                       room;
  logic [kst_pkg::MASK_W-1:0] mod;
  logic                       deliver;
  logic [CNT_W+kst_pkg::HELD_W-1:0] cnt_ext;

  assign end_dec = end_r - CNT_W'(1);
  assign rd_idx  = cmd.rd_last ? end_dec[IDX_W-1:0] : k_r[IDX_W-1:0];
  assign room    = (end_r < kst_pkg::MAX_CNT);
  assign mod     = kst_pkg::modifier_of(key_r);

  assign sts.is_term   = (key_r == kst_pkg::KC_BACKSPACE) &&
                         (mask_r == (kst_pkg::MOD_CTRL | kst_pkg::MOD_ALT));
  assign sts.scan_done = (k_r >= end_r);
  assign sts.hit       = (rdata_r == key_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  // Result packing, lowest bit first.
  assign deliver = focus_r && !term_r;
  assign cnt_ext = {{kst_pkg::HELD_W{1'b0}}, count_r};

  always_comb begin
    out_nxt        = '0;
    out_nxt[0]     = term_r;
    out_nxt[1]     = deliver;
    out_nxt[9:2]   = deliver ? key_r : '0;
    out_nxt[10]    = deliver && press_r;
    out_nxt[42:11] = deliver ? ts_r : '0;
    out_nxt[45:43] = mask_r;
    out_nxt[50:46] = cnt_ext[kst_pkg::HELD_W-1:0];
    out_nxt[51]    = ovf_r;
  end

  // Held-key memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd_k || cmd.rd_last) begin
      rdata_r <= mem[rd_idx];
    end
    if (cmd.swap_wr) begin
      mem[k_r[IDX_W-1:0]] <= rdata_r;
    end else if (cmd.append && press_r && room) begin
      mem[end_r[IDX_W-1:0]] <= key_r;
    end
  end

  // Item capture and per-item flags.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r   <= in_tdata[7:0];
      press_r <= in_tdata[8];
      focus_r <= in_tdata[9];
      ts_r    <= in_tdata[41:10];
      term_r  <= 1'b0;
      ovf_r   <= 1'b0;
    end
    if (cmd.check) begin
      term_r <= sts.is_term;
    end
    if (cmd.append) begin
      ovf_r <= press_r && !room;
    end
    if (cmd.emit) begin
      out_data_r <= out_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      count_r     <= '0;
      k_r         <= '0;
      end_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        k_r   <= '0;
        end_r <= count_r;
      end
      if (cmd.check && !sts.is_term) begin
        mask_r <= press_r ? (mask_r | mod) : (mask_r & ~mod);
      end
      if (cmd.rd_last) begin
        end_r <= end_dec;
      end
      if (cmd.step_k) begin
        k_r <= k_r + CNT_W'(1);
      end
      if (cmd.append) begin
        count_r <= (press_r && room) ? end_r + CNT_W'(1) : end_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kst_pkg::MAX_CNT)
    else $error("kst_datapath: held count above capacity");
  // Removing the last entry leaves the scan position one past the shrunk end.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    k_r <= end_r + CNT_W'(1))
    else $error("kst_datapath: scan position past end of list");
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[0]) |-> (!out_data_r[1] && !out_data_r[51]))
    else $error("kst_datapath: terminate result delivered or overflowed");
`endif

endmodule

// ----- rtl/key_state_tracker.sv -----
// Top level of the key state tracker: joins the controller and the datapath.
// Depends on kst_pkg, kst_ctrl and kst_datapath.
`timescale 1ns / 1ps
//
// Channel   Direction  Width  Content
// in_*      slave      48     one key event
// out_*     master     56     one result item per event
//
// The terminate combination skips the removal scan. Otherwise the scan reads
// the held-key memory through its single read port, one entry at a time, and
// each entry that it removes adds a swap write before the scan moves on.
// Reset is synchronous and active low; it clears the mask and the count, and
// held-key entries need no clearing because only entries below the count are
// read. A new item is accepted while a finished result still waits in the
// output register; a stalled output holds the next result in its last state.
//
// The block tracks a ctrl/alt/super mask and an unordered list of held keys.
// Each event removes any copy of its key by swapping in the last entry, and a
// press then appends the key unless the list is full, which raises an
// overflow flag. Backspace with exactly ctrl+alt held raises a terminate
// request and leaves the mask and list alone. Events are marked for delivery
// when a focus target exists and the event raises no terminate request.

module key_state_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] key_code, [8] pressed, [9] has_focus, [41:10] timestamp, [47:42] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] terminate_request, [1] deliver_event, [9:2] event_key,
  // [10] event_pressed, [42:11] event_time, [45:43] modifiers_now,
  // [50:46] held_total, [51] list_overflow, [55:52] zero
  output logic [55:0] out_tdata
);

  kst_pkg::kst_cmd_t cmd;
  kst_pkg::kst_sts_t sts;

  // The controller steps through capture, check, scan, append and emit; a terminate skips scan and append.
  kst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the list memory, the mask and the output register.
  kst_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
